@@ src/crc8_frame_checker_range_classifier_top_macros.svh @@
// Assertion macros for the CRC-8 frame checker.
// Included by the top level; needs a signal named clock and a signal named reset in scope.
`ifndef CRC8_FRAME_CHECKER_RANGE_CLASSIFIER_TOP_MACROS_SVH
`define CRC8_FRAME_CHECKER_RANGE_CLASSIFIER_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CRC8FC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define CRC8FC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ src/crc8fc_pkg.sv @@
// Shared constants, codes and the CRC-8 byte update for the frame checker.
// No dependencies; imported by the classifier and the top level.
package crc8fc_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 6;
   localparam int RANGE_W  = 3;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 32;
   localparam int TEMP_W   = 15;
   localparam int CSR_IDX_W = 2;

   // default frame length, crc byte included
   localparam int FRAME_BYTES_DEF = 9;

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HEAD_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TICK     = 2'd3;

   // command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_RANGE = 2'd3;

   // register reset values
   localparam logic [BYTE_W-1:0]  HEADER_BYTE_RST    = 8'h5A;
   localparam logic [BYTE_W-1:0]  ERROR_LIMIT_RST    = 8'd250;
   localparam logic [BYTE_W-1:0]  SILENCE_LIMIT_RST  = 8'd120;
   localparam logic [RANGE_W-1:0] FALLBACK_RANGE_RST = 3'd3;

   // temperature thresholds, ascending, pairs form hysteresis bands
   localparam int NUM_THRESH = 10;
   localparam logic [TEMP_W-1:0] THRESHOLDS [NUM_THRESH] = '{
      15'd120, 15'd131, 15'd180, 15'd191, 15'd220,
      15'd231, 15'd270, 15'd281, 15'd340, 15'd351
   };

   // reflected CRC-8, polynomial 0x31 reversed
   localparam logic [BYTE_W-1:0] CRC_POLY_REV = 8'h8C;

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ src/crc8fc_range_classify.sv @@
// Ambient range classifier: temperature = high*100 + low against ten thresholds.
// Depends on crc8fc_pkg for widths and the threshold table.
module crc8fc_range_classify
   import crc8fc_pkg::*;
(
   input  logic [BYTE_W-1:0]  temp_high,
   input  logic [BYTE_W-1:0]  temp_low,
   input  logic [RANGE_W-1:0] range_now,
   output logic [RANGE_W-1:0] range_next
);

   logic [TEMP_W-1:0]     temp;
   logic [NUM_THRESH-1:0] above;
   logic [3:0]            band;

   // form the temperature value
   assign temp = TEMP_W'(temp_high) * TEMP_W'(100) + TEMP_W'(temp_low);

   // compare against every threshold at once
   always_comb begin
      for (int k = 0; k < NUM_THRESH; k++) begin
         above[k] = (temp > THRESHOLDS[k]);
      end
   end

   // thresholds ascend, so the count of those passed is the band index
   assign band = 4'($countones(above));

   // even band maps straight to a range; odd band sits in a hysteresis gap
   always_comb begin
      if (!band[0]) begin
         range_next = band[3:1];
      end else if (range_now != band[3:1]) begin
         range_next = band[3:1] + RANGE_W'(1);
      end else begin
         range_next = range_now;
      end
   end

endmodule

@@ src/crc8_frame_checker_range_classifier_top.sv @@
// Top level of the CRC-8 frame checker and ambient range classifier.
// Depends on crc8fc_pkg, crc8fc_range_classify and the assertion macro header.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata rx_byte, tlast frame_end, tuser cmd
// rsp      out  rsp_tvalid/rsp_tready  tdata comm/range/flags/data_word, tuser status/data_write
// csr      in   csr_we                 csr_index, csr_wdata
//
// One beat is taken per cycle while req_tready is high; its state update and any result are ready in the next cycle.
// Bytes that are not a frame end give no result; a frame end or a tick gives one.
// Input stalls only while the result register is full and rsp_tready is low.
// Synchronous active-high reset clears all state but the result payload and loads the register defaults.
module crc8_frame_checker_range_classifier_top
   import crc8fc_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   input  logic                 req_tlast,   // frame_end
   input  logic                 req_tuser,   // cmd
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [0] comm_error, [3:1] ambient_range,
                                             // [4] short_time_flag, [5] sensor_error_flag,
                                             // [37:6] data_word, [39:38] zero
   output logic [2:0]           rsp_tuser,   // [1:0] frame_status, [2] data_write
   // configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

   // configuration registers
   logic [BYTE_W-1:0]  header_byte_ff, error_limit_ff, silence_limit_ff;
   logic [RANGE_W-1:0] fallback_range_ff;

   // frame and classifier state
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0]  first_byte_ff, first_byte_in;
   logic [BYTE_W-1:0]  temp_high_ff, temp_high_in;
   logic [BYTE_W-1:0]  temp_low_ff, temp_low_in;
   logic [2:0]         flag_byte_ff, flag_byte_in;
   logic [WORD_W-1:0]  payload_ff, payload_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic               comm_ff, comm_in;
   logic [BYTE_W-1:0]  crc_cnt_ff, crc_cnt_in;
   logic [BYTE_W-1:0]  head_cnt_ff, head_cnt_in;
   logic [BYTE_W-1:0]  silence_ff, silence_in;
   logic [1:0]         flags_ff, flags_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_dw_ff, out_dw_in;
   logic [WORD_W-1:0]   out_word_ff, out_word_in;
   logic                out_comm_ff;
   logic [RANGE_W-1:0]  out_range_ff;
   logic [1:0]          out_flags_ff;

   logic               req_fire;
   logic               produce;
   logic [RANGE_W-1:0] range_class;
   logic [1:0]         good_flags;

   // accept while the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign produce    = (req_tuser == CMD_TICK) || req_tlast;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff    <= HEADER_BYTE_RST;
         error_limit_ff    <= ERROR_LIMIT_RST;
         silence_limit_ff  <= SILENCE_LIMIT_RST;
         fallback_range_ff <= FALLBACK_RANGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_BYTE:    header_byte_ff    <= csr_wdata;
            CSR_ERROR_LIMIT:    error_limit_ff    <= csr_wdata;
            CSR_SILENCE_LIMIT:  silence_limit_ff  <= csr_wdata;
            CSR_FALLBACK_RANGE: fallback_range_ff <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   crc8fc_range_classify u_classify (
      .temp_high  (temp_high_ff),
      .temp_low   (temp_low_ff),
      .range_now  (range_ff),
      .range_next (range_class)
   );

   // short time from bit 0, sensor error from bit 2
   assign good_flags = {flag_byte_ff[2], flag_byte_ff[0]};

   // next state for one accepted beat
   always_comb begin
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      first_byte_in = first_byte_ff;
      temp_high_in  = temp_high_ff;
      temp_low_in   = temp_low_ff;
      flag_byte_in  = flag_byte_ff;
      payload_in    = payload_ff;
      range_in      = range_ff;
      comm_in       = comm_ff;
      crc_cnt_in    = crc_cnt_ff;
      head_cnt_in   = head_cnt_ff;
      silence_in    = silence_ff;
      flags_in      = flags_ff;
      out_status_in = STATUS_TICK;
      out_dw_in     = 1'b0;
      out_word_in   = '0;

      if (req_fire) begin
         if (req_tuser == CMD_TICK) begin
            // count silence, flag comm error at the limit
            if (silence_ff < silence_limit_ff) begin
               silence_in = silence_ff + BYTE_W'(1);
            end else begin
               comm_in  = 1'b1;
               range_in = fallback_range_ff;
            end
            out_status_in = STATUS_TICK;
         end else if (!req_tlast) begin
            // capture frame bytes by position and advance the crc
            case (pos_ff)
               6'd0: first_byte_in = req_tdata;
               6'd1: temp_high_in  = req_tdata;
               6'd2: temp_low_in   = req_tdata;
               6'd3: flag_byte_in  = req_tdata[2:0];
               6'd4: payload_in[7:0]   = req_tdata;
               6'd5: payload_in[15:8]  = req_tdata;
               6'd6: payload_in[23:16] = req_tdata;
               6'd7: payload_in[31:24] = req_tdata;
               default: ;
            endcase
            crc_in = crc8_update(crc_ff, req_tdata);
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            // frame end: header, then length and crc
            if (pos_ff == '0 || first_byte_ff != header_byte_ff) begin
               out_status_in = STATUS_HEAD_ERR;
               if (head_cnt_ff < error_limit_ff) begin
                  head_cnt_in = head_cnt_ff + BYTE_W'(1);
               end else begin
                  head_cnt_in = '0;
                  comm_in     = 1'b1;
                  range_in    = fallback_range_ff;
               end
            end else if (pos_ff != LAST_POS || req_tdata != crc_ff) begin
               out_status_in = STATUS_CRC_ERR;
               if (crc_cnt_ff < error_limit_ff) begin
                  crc_cnt_in = crc_cnt_ff + BYTE_W'(1);
               end else begin
                  crc_cnt_in = '0;
                  comm_in    = 1'b1;
                  range_in   = fallback_range_ff;
               end
            end else begin
               out_status_in = STATUS_GOOD;
               flags_in      = good_flags;
               if (flag_byte_ff[1]) begin
                  out_dw_in   = 1'b1;
                  out_word_in = payload_ff;
               end
               range_in    = good_flags[1] ? fallback_range_ff : range_class;
               comm_in     = 1'b0;
               crc_cnt_in  = '0;
               head_cnt_in = '0;
               silence_in  = '0;
            end
            crc_in = '0;
            pos_in = '0;
         end
      end
   end

   // load a result on frame end or tick, drop it once taken
   always_comb begin
      if (req_fire && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= '0;
         pos_ff        <= '0;
         first_byte_ff <= '0;
         temp_high_ff  <= '0;
         temp_low_ff   <= '0;
         flag_byte_ff  <= '0;
         payload_ff    <= '0;
         range_ff      <= '0;
         comm_ff       <= 1'b0;
         crc_cnt_ff    <= '0;
         head_cnt_ff   <= '0;
         silence_ff    <= '0;
         flags_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         pos_ff        <= pos_in;
         first_byte_ff <= first_byte_in;
         temp_high_ff  <= temp_high_in;
         temp_low_ff   <= temp_low_in;
         flag_byte_ff  <= flag_byte_in;
         payload_ff    <= payload_in;
         range_ff      <= range_in;
         comm_ff       <= comm_in;
         crc_cnt_ff    <= crc_cnt_in;
         head_cnt_ff   <= head_cnt_in;
         silence_ff    <= silence_in;
         flags_ff      <= flags_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, held until a new result is loaded
   always_ff @(posedge clock) begin
      if (req_fire && produce) begin
         out_status_ff <= out_status_in;
         out_dw_ff     <= out_dw_in;
         out_word_ff   <= out_word_in;
         out_comm_ff   <= comm_in;
         out_range_ff  <= range_in;
         out_flags_ff  <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_word_ff, out_flags_ff[1], out_flags_ff[0],
                        out_range_ff, out_comm_ff};
   assign rsp_tuser  = {out_dw_ff, out_status_ff};

`include "crc8_frame_checker_range_classifier_top_macros.svh"

   `CRC8FC_ASSERT(a_frame_end_restarts,
      req_fire && req_tuser == CMD_BYTE && req_tlast |=> pos_ff == '0 && crc_ff == '0,
      "crc or byte position not restarted after frame end")
   `CRC8FC_ASSERT(a_result_loaded,
      req_fire && produce |=> rsp_valid_ff,
      "frame end or tick beat left no result")
   `CRC8FC_ASSERT(a_good_clears_errors,
      rsp_valid_ff && out_status_ff == STATUS_GOOD |->
         !comm_ff && crc_cnt_ff == '0 && head_cnt_ff == '0,
      "good frame result while error state is still set")
   `CRC8FC_ASSERT_ALWAYS(a_data_only_good,
      rsp_valid_ff && out_dw_ff |-> out_status_ff == STATUS_GOOD,
      "data published on a result that is not a good frame")

endmodule
